>>> rtl/grouped_conv2d_engine_unit_macros.svh
// Assertion helpers for the convolution engine
`ifndef GROUPED_CONV2D_ENGINE_UNIT_MACROS_SVH
`define GROUPED_CONV2D_ENGINE_UNIT_MACROS_SVH

// Implication checked every cycle outside reset
`define GCE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset
`define GCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/gce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gce_pkg;
  localparam int MaxChannels = 16;
  localparam int MaxKernel   = 5;
  localparam int MaxDim      = 32;
  localparam int Ksq         = MaxKernel * MaxKernel;
  localparam int WDepth      = MaxChannels * MaxChannels * Ksq;
  localparam int SDepth      = MaxChannels * MaxDim * MaxDim;
  localparam int WAddrW      = $clog2(WDepth);
  localparam int SAddrW      = $clog2(SDepth);

  localparam logic [1:0] OP_WEIGHT  = 2'd0;
  localparam logic [1:0] OP_BIAS    = 2'd1;
  localparam logic [1:0] OP_SAMPLE  = 2'd2;
  localparam logic [1:0] OP_COMPUTE = 2'd3;

  localparam logic [2:0] REG_IN_CH  = 3'd0;
  localparam logic [2:0] REG_OUT_CH = 3'd1;
  localparam logic [2:0] REG_KERNEL = 3'd2;
  localparam logic [2:0] REG_STEP   = 3'd3;
  localparam logic [2:0] REG_PAD    = 3'd4;
  localparam logic [2:0] REG_GROUPS = 3'd5;
  localparam logic [2:0] REG_HEIGHT = 3'd6;
  localparam logic [2:0] REG_WIDTH  = 3'd7;

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         out_chan;
    logic [3:0]         in_chan;
    logic [4:0]         row;
    logic [4:0]         col;
    logic signed [15:0] value;
    logic signed [31:0] bias_value;
  } gce_in_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               saturated;
    logic               bad_index;
  } gce_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch item, start setup
    logic setup;     // derive bounds
    logic clear;     // clear accumulator, zero tap counters
    logic issue;     // issue reads for current tap, advance counters
    logic mac;       // accumulate product of data read last cycle
    logic finish;    // add bias and saturate into output register
  } gce_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_compute;
    logic bad;
    logic last_tap;
  } gce_sts_t;
endpackage
`default_nettype wire

>>> rtl/gce_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module gce_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/gce_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module gce_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [5:0]        cfg_data,
  input  wire gce_pkg::gce_in_t  item,
  input  wire gce_pkg::gce_cmd_t cmd,
  output gce_pkg::gce_sts_t      sts,
  output gce_pkg::gce_out_t      res
);
  import gce_pkg::*;

  logic [4:0] in_ch_r, out_ch_r, groups_r;
  logic [2:0] kern_r, step_r, pad_r;
  logic [5:0] height_r, width_r;

  gce_in_t item_r;
  logic [31:0] bias_r [MaxChannels];
  logic [MaxChannels-1:0] bias_v_r;

  // bounds derived in setup, tap counters, accumulator
  logic        bad_r;
  logic [4:0]  icpg_r, gbase_r;
  logic [3:0]  i_r;
  logic [2:0]  kh_r, kw_r;
  logic        pv_r, mv_r;
  logic signed [47:0] acc_r;
  logic signed [31:0] prod_r;
  gce_out_t    res_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ch_r <= 5'd1; out_ch_r <= 5'd1; kern_r <= 3'd3; step_r <= 3'd1;
      pad_r <= 3'd0; groups_r <= 5'd1; height_r <= 6'd32; width_r <= 6'd32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IN_CH:  in_ch_r  <= cfg_data[4:0];
        REG_OUT_CH: out_ch_r <= cfg_data[4:0];
        REG_KERNEL: kern_r   <= cfg_data[2:0];
        REG_STEP:   step_r   <= cfg_data[2:0];
        REG_PAD:    pad_r    <= cfg_data[2:0];
        REG_GROUPS: groups_r <= cfg_data[4:0];
        REG_HEIGHT: height_r <= cfg_data;
        default:    width_r  <= cfg_data;
      endcase
    end
  end

  // load addresses
  logic [WAddrW-1:0] w_waddr, w_raddr;
  logic [SAddrW-1:0] s_waddr, s_raddr;
  logic w_we, s_we;
  assign w_waddr = WAddrW'((32'(item.out_chan) * MaxChannels + 32'(item.in_chan)) * Ksq
                   + 32'(item.row) * MaxKernel + 32'(item.col));
  assign s_waddr = {item.in_chan, item.row, item.col};
  assign w_we = cmd.load && item.op == OP_WEIGHT && item.row < 5'(MaxKernel)
                && item.col < 5'(MaxKernel);
  assign s_we = cmd.load && item.op == OP_SAMPLE;

  // bias store with valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_v_r <= '0;
    end else if (cmd.load && item.op == OP_BIAS) begin
      bias_v_r[item.out_chan] <= 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.load && item.op == OP_BIAS) begin
      bias_r[item.out_chan] <= item.bias_value;
    end
  end

  // divisibility via multiples (groups <= 16, channels <= 16)
  logic [4:0] icpg_c, ocpg_c;
  logic       idiv, odiv;
  always_comb begin
    icpg_c = '0; ocpg_c = '0; idiv = 1'b0; odiv = 1'b0;
    for (int q = 1; q <= 16; q++) begin
      if (9'(groups_r) * 9'(q) == 9'(in_ch_r)) begin idiv = 1'b1; icpg_c = 5'(q); end
      if (9'(groups_r) * 9'(q) == 9'(out_ch_r)) begin odiv = 1'b1; ocpg_c = 5'(q); end
    end
  end

  // output size: count of stride steps fitting in span
  logic [6:0] span_h, span_w;
  logic [5:0] oh_c, ow_c;
  logic       cfg_ok;
  assign span_h = 7'(height_r) + 7'({pad_r, 1'b0}) - 7'(kern_r);
  assign span_w = 7'(width_r) + 7'({pad_r, 1'b0}) - 7'(kern_r);
  always_comb begin
    unique case (step_r)
      3'd1: begin oh_c = 6'(span_h); ow_c = 6'(span_w); end
      3'd2: begin oh_c = 6'(span_h >> 1); ow_c = 6'(span_w >> 1); end
      3'd4: begin oh_c = 6'(span_h >> 2); ow_c = 6'(span_w >> 2); end
      default: begin oh_c = 6'(7'((14'(span_h) * 14'd43) >> 7));
        ow_c = 6'(7'((14'(span_w) * 14'd43) >> 7)); end
    endcase
  end
  assign cfg_ok = in_ch_r >= 5'd1 && in_ch_r <= 5'd16 && out_ch_r >= 5'd1
    && out_ch_r <= 5'd16 && kern_r >= 3'd1 && kern_r <= 3'd5 && step_r >= 3'd1
    && step_r <= 3'd4 && pad_r <= 3'd4 && groups_r >= 5'd1 && idiv && odiv
    && height_r >= 6'd1 && height_r <= 6'd32 && width_r >= 6'd1 && width_r <= 6'd32
    && 7'(height_r) + 7'({pad_r, 1'b0}) >= 7'(kern_r)
    && 7'(width_r) + 7'({pad_r, 1'b0}) >= 7'(kern_r);

  // group index of out_chan: count multiples of ocpg at or below it
  logic [4:0] grp_c;
  always_comb begin
    grp_c = '0;
    for (int q = 1; q < 16; q++) begin
      if (9'(ocpg_c) * 9'(q) <= 9'(item_r.out_chan) && ocpg_c != 5'd0) grp_c = 5'(q);
    end
  end

  // item latch and setup
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= item;
    if (cmd.setup) begin
      bad_r  <= !cfg_ok || 5'(item_r.out_chan) >= out_ch_r
                || 6'(item_r.row) > oh_c || 6'(item_r.col) > ow_c;
      icpg_r <= icpg_c;
      gbase_r <= 5'(9'(grp_c) * 9'(icpg_c));
    end
  end

  // tap position
  logic signed [8:0] h_c, w_c;
  logic        inb_c;
  logic [3:0]  gic_c;
  assign h_c = 9'(10'(item_r.row) * 10'(step_r)) + 9'(kh_r) - 9'(pad_r);
  assign w_c = 9'(10'(item_r.col) * 10'(step_r)) + 9'(kw_r) - 9'(pad_r);
  assign inb_c = h_c >= 0 && w_c >= 0 && h_c < 9'(height_r) && w_c < 9'(width_r);
  assign gic_c = 4'(gbase_r + 5'(i_r));
  assign w_raddr = WAddrW'((32'(item_r.out_chan) * MaxChannels + 32'(i_r)) * Ksq
                   + 32'(kh_r) * MaxKernel + 32'(kw_r));
  assign s_raddr = {gic_c, h_c[4:0], w_c[4:0]};

  logic last_kw, last_kh, last_i;
  assign last_kw = kw_r == kern_r - 3'd1;
  assign last_kh = kh_r == kern_r - 3'd1;
  assign last_i  = 5'(i_r) == icpg_r - 5'd1;

  logic [15:0] w_q, s_q;
  gce_ram #(.Width(16), .Depth(WDepth)) u_wram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(item.value),
    .raddr(w_raddr), .rdata(w_q));
  gce_ram #(.Width(16), .Depth(SDepth)) u_sram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(item.value),
    .raddr(s_raddr), .rdata(s_q));

  // tap counters, multiply, accumulate, add bias and saturate
  logic signed [47:0] sum_c;
  logic [31:0] bias_c;
  assign bias_c = bias_v_r[item_r.out_chan] ? bias_r[item_r.out_chan] : 32'd0;
  assign sum_c  = acc_r + 48'(signed'(bias_c));
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0; mv_r <= 1'b0;
    end else begin
      pv_r <= cmd.issue && inb_c;
      mv_r <= cmd.mac && pv_r;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      i_r <= '0; kh_r <= '0; kw_r <= '0; acc_r <= '0;
    end else begin
      if (cmd.issue) begin
        if (!last_kw) kw_r <= kw_r + 3'd1;
        else begin
          kw_r <= '0;
          if (!last_kh) kh_r <= kh_r + 3'd1;
          else begin kh_r <= '0; i_r <= i_r + 4'd1; end
        end
      end
      if (mv_r) acc_r <= acc_r + 48'(prod_r);
    end
    prod_r <= signed'(s_q) * signed'(w_q);
    if (cmd.finish) begin
      if (bad_r) res_r <= '{result: '0, saturated: 1'b0, bad_index: 1'b1};
      else if (sum_c > 48'sh7FFFFFFF)
        res_r <= '{result: 32'h7FFFFFFF, saturated: 1'b1, bad_index: 1'b0};
      else if (sum_c < -48'sh80000000)
        res_r <= '{result: 32'h80000000, saturated: 1'b1, bad_index: 1'b0};
      else res_r <= '{result: sum_c[31:0], saturated: 1'b0, bad_index: 1'b0};
    end
  end

  assign sts = '{is_compute: item_r.op == OP_COMPUTE, bad: bad_r,
                 last_tap: last_kw && last_kh && last_i};
  assign res = res_r;
endmodule
`default_nettype wire

>>> rtl/gce_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "grouped_conv2d_engine_unit_macros.svh"
module gce_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire gce_pkg::gce_sts_t sts,
  output gce_pkg::gce_cmd_t      cmd
);
  import gce_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SETUP, S_ISSUE, S_DRAIN1, S_DRAIN2, S_DRAIN3,
                            S_DONE} state_t;
  state_t state_r;
  logic   out_valid_r;
  logic   take;
  logic   fire;

  assign take = in_valid && !in_stall;
  assign in_stall = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  // result register is free once the waiting transfer leaves
  assign fire = state_r == S_DONE && (!out_valid_r || !out_stall);

  always_comb begin
    cmd = '0;
    cmd.load   = take;
    cmd.setup  = state_r == S_SETUP;
    cmd.clear  = state_r == S_SETUP;
    cmd.issue  = state_r == S_ISSUE;
    cmd.mac    = state_r == S_ISSUE || state_r == S_DRAIN1;
    cmd.finish = fire;
  end

  // sequence one item: setup, then for a compute the tap walk, pipeline drain, result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; out_valid_r <= 1'b0;
    end else begin
      if (fire) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE:   if (take) state_r <= S_SETUP;
        S_SETUP:  state_r <= !sts.is_compute ? S_IDLE : S_ISSUE;
        S_ISSUE:  if (sts.bad || sts.last_tap) state_r <= S_DRAIN1;
        S_DRAIN1: state_r <= S_DRAIN2;
        S_DRAIN2: state_r <= S_DRAIN3;
        S_DRAIN3: state_r <= S_DONE;
        default:  if (fire) state_r <= S_IDLE;
      endcase
    end
  end

  `GCE_ASSERT_IMP(a_no_take_busy, state_r != S_IDLE, !take)
  `GCE_ASSERT_NEXT(a_done_valid, state_r == S_DONE, out_valid_r)
  `GCE_ASSERT_NEXT(a_valid_hold, out_valid_r && out_stall, out_valid_r)
endmodule
`default_nettype wire

>>> rtl/grouped_conv2d_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Grouped 2D convolution engine. Load items (weight, bias, sample) only pass setup; a
// compute item is paced by the single multiply-accumulate that walks every channel
// and kernel tap of the group, one tap per cycle through the weight and sample RAM
// read ports; a flagged item ends its tap walk after the first tap.
// One item at a time; a finished result waits in the output register while further
// items are taken, and the next result is held back until that transfer leaves.
module grouped_conv2d_engine_unit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire gce_pkg::gce_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output gce_pkg::gce_out_t     out_data,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [5:0]       cfg_data
);
  import gce_pkg::*;

  gce_cmd_t cmd;
  gce_sts_t sts;

  gce_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd));

  gce_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .item(in_data), .cmd(cmd), .sts(sts), .res(out_data));
endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import gce_pkg::*;

  localparam int IdleLimit = 20000;
  localparam int SettleCycles = 450;
  localparam int TargetItems = 1300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  gce_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  gce_out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [5:0] cfg_data = '0;

  grouped_conv2d_engine_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Register copy shared by the item planner and the convolution predictor
  int n_in_ch = 1, n_out_ch = 1, ksize = 3, stride = 1, pad = 0;
  int groups = 1, img_h = 32, img_w = 32;

  logic signed [15:0] weight_mem [WDepth];
  logic signed [15:0] sample_mem [SDepth];
  logic signed [31:0] bias_mem [MaxChannels];
  bit weight_loaded [WDepth];
  bit sample_loaded [SDepth];

  gce_in_t pending_items [$];
  gce_out_t due_results [$];

  int cyc = 0;
  int mismatches = 0;
  int n_checked = 0, n_sat = 0, n_bad = 0, n_phases = 0, planned = 0;
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  initial begin
    for (int a = 0; a < WDepth; a++) weight_mem[a] = '0;
    for (int a = 0; a < SDepth; a++) sample_mem[a] = '0;
    for (int a = 0; a < MaxChannels; a++) bias_mem[a] = '0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int weight_addr(int oc, int ic, int r, int c);
    return (oc * MaxChannels + ic) * Ksq + r * MaxKernel + c;
  endfunction

  function automatic int sample_addr(int ch, int r, int c);
    return ch * MaxDim * MaxDim + r * MaxDim + c;
  endfunction

  function automatic bit cfg_legal();
    if (n_in_ch < 1 || n_in_ch > MaxChannels) return 0;
    if (n_out_ch < 1 || n_out_ch > MaxChannels) return 0;
    if (ksize < 1 || ksize > MaxKernel) return 0;
    if (stride < 1 || stride > 4) return 0;
    if (pad > 4) return 0;
    if (groups < 1) return 0;
    if (n_in_ch % groups != 0 || n_out_ch % groups != 0) return 0;
    if (img_h < 1 || img_h > MaxDim || img_w < 1 || img_w > MaxDim) return 0;
    if (img_h + 2 * pad < ksize || img_w + 2 * pad < ksize) return 0;
    return 1;
  endfunction

  function automatic int out_rows();
    return (img_h + 2 * pad - ksize) / stride + 1;
  endfunction

  function automatic int out_cols();
    return (img_w + 2 * pad - ksize) / stride + 1;
  endfunction

  // Convolve one output point; flag any read of a never-loaded entry
  function automatic gce_out_t conv_point(gce_in_t it, output bit blank);
    gce_out_t o;
    int icpg, ocpg, grp, oc, h, w, wa, sa;
    longint acc;
    blank = 1'b0;
    o.result = '0;
    o.saturated = 1'b0;
    o.bad_index = 1'b1;
    if (!cfg_legal()) return o;
    oc = int'(it.out_chan);
    if (oc >= n_out_ch || int'(it.row) >= out_rows() || int'(it.col) >= out_cols()) return o;
    icpg = n_in_ch / groups;
    ocpg = n_out_ch / groups;
    grp = oc / ocpg;
    acc = 0;
    for (int i = 0; i < icpg; i++) begin
      for (int kh = 0; kh < ksize; kh++) begin
        for (int kw = 0; kw < ksize; kw++) begin
          h = int'(it.row) * stride + kh - pad;
          w = int'(it.col) * stride + kw - pad;
          if (h < 0 || w < 0 || h >= img_h || w >= img_w) continue;
          wa = weight_addr(oc, i, kh, kw);
          sa = sample_addr(grp * icpg + i, h, w);
          if (!weight_loaded[wa] || !sample_loaded[sa]) blank = 1'b1;
          acc += longint'(sample_mem[sa]) * longint'(weight_mem[wa]);
        end
      end
    end
    acc += longint'(bias_mem[oc]);
    if (acc > 64'sd2147483647) begin
      acc = 64'sd2147483647;
      o.saturated = 1'b1;
    end
    if (acc < -64'sd2147483648) begin
      acc = -64'sd2147483648;
      o.saturated = 1'b1;
    end
    o.result = acc[31:0];
    o.bad_index = 1'b0;
    return o;
  endfunction

  // Queue an item unless it is a compute that would read a never-loaded entry
  function automatic bit offer(gce_in_t it);
    bit blank;
    gce_out_t unused;
    if (it.op == OP_COMPUTE) begin
      unused = conv_point(it, blank);
      if (blank) return 0;
    end else if (it.op == OP_WEIGHT) begin
      if (it.row < MaxKernel && it.col < MaxKernel)
        weight_loaded[weight_addr(it.out_chan, it.in_chan, it.row, it.col)] = 1'b1;
    end else if (it.op == OP_SAMPLE) begin
      sample_loaded[sample_addr(it.in_chan, it.row, it.col)] = 1'b1;
    end
    pending_items.push_back(it);
    planned++;
    return 1;
  endfunction

  function automatic gce_in_t make_item(logic [1:0] op, int oc, int ic, int r, int c,
                                        int v, int b);
    gce_in_t it;
    it.op = op;
    it.out_chan = oc[3:0];
    it.in_chan = ic[3:0];
    it.row = r[4:0];
    it.col = c[4:0];
    it.value = v[15:0];
    it.bias_value = b;
    return it;
  endfunction

  function automatic gce_in_t rand_item(logic [1:0] op);
    return make_item(op, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // Wait until the block is idle with nothing outstanding
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic configure(int ic, int oc, int k, int s, int p, int g, int h, int w);
    int vals [8];
    drain();
    vals = '{ic, oc, k, s, p, g, h, w};
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= vals[i][5:0];
      case (i[2:0])
        REG_IN_CH:  n_in_ch = vals[i] & 31;
        REG_OUT_CH: n_out_ch = vals[i] & 31;
        REG_KERNEL: ksize = vals[i] & 7;
        REG_STEP:   stride = vals[i] & 7;
        REG_PAD:    pad = vals[i] & 7;
        REG_GROUPS: groups = vals[i] & 31;
        REG_HEIGHT: img_h = vals[i] & 63;
        default:    img_w = vals[i] & 63;
      endcase
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    n_phases++;
  endtask

  // Load weights, biases and a corner of the image for every output channel, or the first and last only
  task automatic fill_phase();
    int icpg, ocpg, oc, rows, cols;
    int oc_list [$];
    bit ok;
    if (!cfg_legal()) return;
    icpg = n_in_ch / groups;
    ocpg = n_out_ch / groups;
    if (n_out_ch * icpg * ksize * ksize <= 120) begin
      for (int o = 0; o < n_out_ch; o++) oc_list.push_back(o);
    end else begin
      oc_list.push_back(0);
      if (n_out_ch > 1) oc_list.push_back(n_out_ch - 1);
    end
    rows = (img_h < 6) ? img_h : 6;
    cols = (img_w < 6) ? img_w : 6;
    foreach (oc_list[n]) begin
      oc = oc_list[n];
      ok = offer(make_item(OP_BIAS, oc, 0, 0, 0, 0, $urandom_range(0, 1 << 22) - (1 << 21)));
      for (int i = 0; i < icpg; i++) begin
        for (int kh = 0; kh < ksize; kh++) begin
          for (int kw = 0; kw < ksize; kw++)
            ok = offer(make_item(OP_WEIGHT, oc, i, kh, kw, $urandom, 0));
        end
        // load each group's samples once
        if (n == 0 || (oc / ocpg) != (oc_list[n - 1] / ocpg)) begin
          for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++)
              ok = offer(make_item(OP_SAMPLE, 0, (oc / ocpg) * icpg + i, r, c, $urandom, 0));
          end
        end
      end
    end
  endtask

  // Mostly well-formed computes, plus stray loads and out-of-range points
  task automatic random_items(int count);
    gce_in_t it;
    bit ok;
    int sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      ok = 1'b0;
      if (sel < 60 && cfg_legal()) begin
        for (int t = 0; t < 8 && !ok; t++) begin
          it = rand_item(OP_COMPUTE);
          it.out_chan = 4'($urandom_range(0, n_out_ch - 1));
          it.row = 5'($urandom_range(0, out_rows() - 1));
          it.col = 5'($urandom_range(0, out_cols() - 1));
          ok = offer(it);
        end
      end else if (sel < 72) begin
        ok = offer(rand_item(OP_COMPUTE));
      end
      if (!ok) ok = offer(rand_item(2'($urandom_range(0, 2))));
    end
  endtask

  task automatic random_phase();
    int g, icpg, ocpg, k, p, h, w;
    if ($urandom_range(0, 5) == 0) begin
      configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom);
    end else begin
      g = 1 << $urandom_range(0, 2);
      icpg = $urandom_range(1, 4);
      ocpg = $urandom_range(1, 4);
      k = $urandom_range(1, 5);
      p = $urandom_range(0, 4);
      h = $urandom_range(1, 7);
      w = $urandom_range(1, 7);
      while (h + 2 * p < k) h++;
      while (w + 2 * p < k) w++;
      configure(g * icpg, g * ocpg, k, $urandom_range(1, 4), p, g, h, w);
    end
    fill_phase();
    random_items(30);
  endtask

  // Stimulus: directed corners first, then randomized phases
  initial begin
    bit ok;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Border-only taps, both saturation directions, ignored loads, bad points
    configure(1, 1, 1, 1, 1, 1, 2, 2);
    ok = offer(make_item(OP_BIAS, 0, 0, 0, 0, 0, 32'h7fffffff));
    ok = offer(make_item(OP_WEIGHT, 0, 0, 0, 0, 32767, 0));
    ok = offer(make_item(OP_SAMPLE, 0, 0, 0, 0, 32767, 0));
    ok = offer(make_item(OP_SAMPLE, 0, 0, 0, 1, -32768, 0));
    ok = offer(make_item(OP_SAMPLE, 0, 0, 1, 0, 256, 0));
    ok = offer(make_item(OP_SAMPLE, 0, 0, 1, 1, -1, 0));
    ok = offer(make_item(OP_COMPUTE, 0, 0, 0, 0, 0, 0));
    ok = offer(make_item(OP_COMPUTE, 0, 0, 1, 1, 0, 0));
    ok = offer(make_item(OP_BIAS, 0, 0, 0, 0, 0, 32'h80000000));
    ok = offer(make_item(OP_COMPUTE, 0, 0, 1, 2, 0, 0));
    ok = offer(make_item(OP_WEIGHT, 0, 0, 5, 0, 1, 0));
    ok = offer(make_item(OP_WEIGHT, 0, 0, 0, 31, 1, 0));
    ok = offer(make_item(OP_WEIGHT, 15, 15, 4, 4, -32768, 0));
    ok = offer(make_item(OP_BIAS, 15, 0, 0, 0, 0, 32'h12345678));
    ok = offer(make_item(OP_SAMPLE, 0, 15, 31, 31, 32767, 0));
    ok = offer(make_item(OP_COMPUTE, 1, 0, 0, 0, 0, 0));
    ok = offer(make_item(OP_COMPUTE, 0, 0, 4, 0, 0, 0));
    ok = offer(make_item(OP_COMPUTE, 0, 0, 0, 31, 0, 0));
    ok = offer(make_item(OP_BIAS, 0, 0, 0, 0, 0, 0));
    ok = offer(make_item(OP_COMPUTE, 0, 0, 2, 2, 0, 0));
    ok = offer(make_item(OP_COMPUTE, 0, 0, 3, 3, 0, 0));
    ok = offer(make_item(OP_COMPUTE, 15, 15, 31, 31, 0, 0));

    // Register extremes, legal and illegal
    configure(16, 16, 5, 4, 4, 16, 32, 32);
    fill_phase();
    random_items(30);
    configure(1, 1, 1, 1, 0, 1, 1, 1);
    fill_phase();
    random_items(20);
    configure(16, 16, 1, 1, 0, 1, 32, 32);
    fill_phase();
    random_items(20);
    configure(4, 4, 0, 1, 0, 3, 4, 4);
    random_items(10);
    configure(31, 31, 7, 0, 7, 0, 0, 63);
    random_items(10);
    configure(1, 1, 5, 1, 1, 1, 1, 1);
    random_items(10);
    configure(2, 2, 3, 5, 5, 2, 33, 4);
    random_items(10);

    while (planned < TargetItems) random_phase();
    drain();

    $display("Ran %0d items over %0d register settings; checked %0d computes", planned,
             n_phases, n_checked);
    $display("  %0d saturated, %0d flagged bad", n_sat, n_bad);
    if (mismatches == 0) begin
      $display("grouped_conv2d_engine_unit verification clean");
    end else begin
      $display("grouped_conv2d_engine_unit verification failed");
    end
    $finish;
  end

  // Input side: predict on each accepted transfer
  always @(posedge clk) begin
    gce_out_t o;
    bit blank;
    cyc <= cyc + 1;
    if (rst_n && in_valid && !in_stall) begin
      case (in_data.op)
        OP_WEIGHT: begin
          if (in_data.row < MaxKernel && in_data.col < MaxKernel)
            weight_mem[weight_addr(in_data.out_chan, in_data.in_chan, in_data.row,
                                   in_data.col)] = in_data.value;
        end
        OP_BIAS:   bias_mem[in_data.out_chan] = in_data.bias_value;
        OP_SAMPLE: sample_mem[sample_addr(in_data.in_chan, in_data.row, in_data.col)] =
                     in_data.value;
        default: begin
          o = conv_point(in_data, blank);
          due_results.push_back(o);
        end
      endcase
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  // Drive the next item at the falling edge, with random gaps
  always @(negedge clk) begin
    bit calm;
    calm = cyc > 15000 && cyc < 35000;
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 23)) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: stall at random, with one long hold-off to back up the input
  always @(negedge clk) begin
    bit calm;
    calm = cyc > 15000 && cyc < 35000;
    if (!hold_done && cyc > 2000 && pending_items.size() > 4) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && $urandom_range(0, 99) < 23;
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    gce_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      out_taken <= 1'b1;
      if (due_results.size() == 0) begin
        mismatches++;
        $error("unexpected result transfer: result %0d", $signed(out_data.result));
      end else begin
        want = due_results.pop_front();
        n_checked++;
        if (want.saturated) n_sat++;
        if (want.bad_index) n_bad++;
        if (out_data.result !== want.result) begin
          mismatches++;
          $error("result: expected %0d, got %0d", $signed(want.result),
                 $signed(out_data.result));
        end
        if (out_data.saturated !== want.saturated) begin
          mismatches++;
          $error("saturated: expected %0b, got %0b", want.saturated, out_data.saturated);
        end
        if (out_data.bad_index !== want.bad_index) begin
          mismatches++;
          $error("bad_index: expected %0b, got %0b", want.bad_index, out_data.bad_index);
        end
      end
    end else begin
      out_taken <= 1'b0;
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    int quiet;
    if (in_taken || out_taken) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
      if (quiet >= IdleLimit) begin
        $display("grouped_conv2d_engine_unit verification failed");
        $finish;
      end
    end
  end

endmodule
